[hdl/ialu_pkg.sv]
// Shared opcodes, error codes and pipeline stage type for the integer ALU.
`default_nettype none
package ialu_pkg;

    localparam int DataWidth = 32;
    localparam int DivSteps  = DataWidth;

    typedef enum logic [3:0] {
        OP_ADD = 4'd0,
        OP_SUB = 4'd1,
        OP_MUL = 4'd2,
        OP_DIV = 4'd3,
        OP_REM = 4'd4,
        OP_SHL = 4'd5,
        OP_SAR = 4'd6,
        OP_AND = 4'd7,
        OP_OR  = 4'd8,
        OP_XOR = 4'd9,
        OP_NOT = 4'd10
    } op_t;

    typedef enum logic [1:0] {
        ERR_NONE    = 2'd0,
        ERR_DIVZERO = 2'd1,
        ERR_SHIFT   = 2'd2,
        ERR_OPCODE  = 2'd3
    } err_t;

    typedef struct packed {
        logic [3:0]           kind;
        logic [1:0]           err;
        logic [DataWidth-1:0] res;
        logic [DataWidth-1:0] rem;
        logic [DataWidth-1:0] quo;
        logic [DataWidth-1:0] den;
        logic                 neg_q;
        logic                 neg_r;
    } stage_t;

endpackage
`default_nettype wire

[hdl/ialu_if.sv]
// Valid/ready channel interfaces for ALU items and results.
`default_nettype none
interface ialu_in_if;
    logic               valid;
    logic               ready;
    logic [3:0]         kind;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
    modport source (output valid, kind, operand_a, operand_b, input ready);
    modport sink   (input valid, kind, operand_a, operand_b, output ready);
endinterface

interface ialu_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] result;
    logic [1:0]         error_code;
    modport source (output valid, result, error_code, input ready);
    modport sink   (input valid, result, error_code, output ready);
endinterface
`default_nettype wire

[hdl/integer_alu_eleven_ops.sv]
// Pipelined 32-bit integer ALU with eleven operations and a pipelined divider.
//
//   channel | dir | fields
//   cmd     | in  | kind[3:0], operand_a[31:0] signed, operand_b[31:0] signed
//   rsp     | out | result[31:0] signed, error_code[1:0]
//
// One item per cycle while the output is not stalled. Items pass a decode register, the
// restoring divider stages and an output register, one quotient bit per stage.
// Reset clears only the valid bits.
// A stalled result freezes every stage; an empty output register lets it move.
`default_nettype none
module integer_alu_eleven_ops (
    input  wire    clk,
    input  wire    rst_n,
    ialu_in_if.sink    cmd,
    ialu_out_if.source rsp
);
    import ialu_pkg::*;

    logic   adv;
    logic   [DivSteps:0] valid_reg;
    stage_t stage_reg [0:DivSteps];
    stage_t stage0_next;
    logic   [DataWidth-1:0] res_reg, res_next;
    logic   [1:0] err_reg;
    logic   out_valid_reg;

    assign adv       = !out_valid_reg || rsp.ready;
    assign cmd.ready = adv;

    // decode, simple ops, divider setup
    always_comb
    begin
        logic [DataWidth-1:0] a, b;
        logic [DataWidth-1:0] prod;
        a    = cmd.operand_a;
        b    = cmd.operand_b;
        // keep only the low word of the product
        prod = a * b;
        stage0_next       = '0;
        stage0_next.kind  = cmd.kind;
        stage0_next.err   = ERR_NONE;
        stage0_next.rem   = '0;
        stage0_next.quo   = a[DataWidth-1] ? (~a + 1'b1) : a;
        stage0_next.den   = b[DataWidth-1] ? (~b + 1'b1) : b;
        stage0_next.neg_q = a[DataWidth-1] ^ b[DataWidth-1];
        stage0_next.neg_r = a[DataWidth-1];
        case (op_t'(cmd.kind))
            OP_ADD: stage0_next.res = a + b;
            OP_SUB: stage0_next.res = a - b;
            OP_MUL: stage0_next.res = prod;
            OP_DIV, OP_REM:
            begin
                if (b == '0)
                    stage0_next.err = ERR_DIVZERO;
            end
            OP_SHL, OP_SAR:
            begin
                if (b > DataWidth'(DataWidth - 1))
                    stage0_next.err = ERR_SHIFT;
                else if (cmd.kind == OP_SHL)
                    stage0_next.res = a << b[4:0];
                else
                    stage0_next.res = DataWidth'($signed(a) >>> b[4:0]);
            end
            OP_AND: stage0_next.res = a & b;
            OP_OR:  stage0_next.res = a | b;
            OP_XOR: stage0_next.res = a ^ b;
            OP_NOT: stage0_next.res = ~a;
            default: stage0_next.err = ERR_OPCODE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg[0] <= 1'b0;
        else if (adv)
            valid_reg[0] <= cmd.valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            stage_reg[0] <= stage0_next;
    end

    // one restoring divide step per stage
    for (genvar i = 1; i <= DivSteps; i++)
    begin : g_div
        stage_t nxt;
        logic [DataWidth:0] shifted, diff;

        always_comb
        begin
            nxt     = stage_reg[i-1];
            shifted = {stage_reg[i-1].rem, stage_reg[i-1].quo[DataWidth-1]};
            diff    = shifted - {1'b0, stage_reg[i-1].den};
            if (!diff[DataWidth])
            begin
                nxt.rem = diff[DataWidth-1:0];
                nxt.quo = {stage_reg[i-1].quo[DataWidth-2:0], 1'b1};
            end
            else
            begin
                nxt.rem = shifted[DataWidth-1:0];
                nxt.quo = {stage_reg[i-1].quo[DataWidth-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[i] <= 1'b0;
            else if (adv)
                valid_reg[i] <= valid_reg[i-1];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
                stage_reg[i] <= nxt;
        end
    end

    // sign fix and select
    always_comb
    begin
        stage_t s;
        s = stage_reg[DivSteps];
        if (s.err != ERR_NONE)
            res_next = '0;
        else if (s.kind == OP_DIV)
            res_next = s.neg_q ? (~s.quo + 1'b1) : s.quo;
        else if (s.kind == OP_REM)
            res_next = s.neg_r ? (~s.rem + 1'b1) : s.rem;
        else
            res_next = s.res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= valid_reg[DivSteps];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            res_reg <= res_next;
            err_reg <= stage_reg[DivSteps].err;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.result     = res_reg;
    assign rsp.error_code = err_reg;

endmodule
`default_nettype wire

[hdl/ialu_checker.sv]
// Port-level checks for the integer ALU, bound to the top level.
`default_nettype none
module ialu_checker (
    input wire        clk,
    input wire        rst_n,
    input wire        in_ready,
    input wire        out_valid,
    input wire        out_ready,
    input wire [31:0] result,
    input wire [1:0]  error_code
);
    import ialu_pkg::*;

    // a failed operation never leaks a value
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && error_code != ERR_NONE |-> result == '0)
        else $error("nonzero result with error");

    // an empty output side never blocks input
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output");

    // a stall at the output stalls the input
    a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input taken during output stall");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(result) && $stable(error_code))
        else $error("stalled result changed");

endmodule

bind integer_alu_eleven_ops ialu_checker u_ialu_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (cmd.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .result    (rsp.result),
    .error_code(rsp.error_code)
);
`default_nettype wire

[dv/integer_alu_eleven_ops_tb.sv]
// Testbench for the pipelined integer ALU: predicted results checked in order.
`timescale 1ns / 1ps
`default_nettype none
module integer_alu_eleven_ops_tb;
    import ialu_pkg::*;

    typedef struct packed {
        logic signed [31:0] result;
        err_t               code;
    } alu_out_t;

    class alu_scoreboard;
        alu_out_t pending[$];
        int       mismatches;
        int       checked;

        function alu_out_t compute(logic [3:0] kind, logic [31:0] a, logic [31:0] b);
            alu_out_t   r;
            logic [31:0] ma;
            logic [31:0] mb;
            r.result = '0;
            r.code   = ERR_NONE;
            ma = a[31] ? -a : a;
            mb = b[31] ? -b : b;
            case (kind)
                OP_ADD: r.result = a + b;
                OP_SUB: r.result = a - b;
                OP_MUL: r.result = a * b;
                OP_DIV, OP_REM:
                    if (b == 0)
                        r.code = ERR_DIVZERO;
                    else if (kind == OP_DIV)
                        r.result = (a[31] != b[31]) ? -(ma / mb) : ma / mb;
                    else
                        r.result = a[31] ? -(ma % mb) : ma % mb;
                OP_SHL, OP_SAR:
                    if (b > 31)
                        r.code = ERR_SHIFT;
                    else if (kind == OP_SHL)
                        r.result = a << b[4:0];
                    else
                        r.result = $signed(a) >>> b[4:0];
                OP_AND: r.result = a & b;
                OP_OR:  r.result = a | b;
                OP_XOR: r.result = a ^ b;
                OP_NOT: r.result = ~a;
                default: r.code = ERR_OPCODE;
            endcase
            return r;
        endfunction

        function void note_command(logic [3:0] kind, logic [31:0] a, logic [31:0] b);
            pending.push_back(compute(kind, a, b));
        endfunction

        function void check_response(logic [31:0] result, logic [1:0] code);
            alu_out_t e;
            checked++;
            if (pending.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected result %h code %0d", $time, result, code);
                return;
            end
            e = pending.pop_front();
            if (e.result !== result || e.code !== code)
            begin
                mismatches++;
                $display("%0t: expected %h code %0d, actual %h code %0d",
                         $time, e.result, e.code, result, code);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    ialu_in_if  cmd ();
    ialu_out_if rsp ();
    alu_scoreboard board;
    int  cycles;
    bit  quiet;
    int  sent;
    int  op_seen[16];

    integer_alu_eleven_ops uut (.clk(clk), .rst_n(rst_n), .cmd(cmd.sink), .rsp(rsp.source));

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        cmd.valid = 1'b0;
        cmd.kind = '0;
        cmd.operand_a = '0;
        cmd.operand_b = '0;
        rsp.ready = 1'b0;
        board = new();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Sample both handshakes just before the edge takes them.
    always @(posedge clk)
    begin
        if (rst_n && cmd.valid && cmd.ready)
        begin
            board.note_command(cmd.kind, cmd.operand_a, cmd.operand_b);
            op_seen[cmd.kind]++;
        end
        if (rst_n && rsp.valid && rsp.ready)
            board.check_response(rsp.result, rsp.error_code);
    end

    // Receiver stalls in bursts.
    initial
    begin
        int n;
        @(posedge rst_n);
        forever
        begin
            if (!quiet && $urandom_range(0, 5) == 0)
            begin
                n = $urandom_range(1, 4);
                rsp.ready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            rsp.ready <= 1'b1;
            @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > 200000)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    function logic [31:0] pick_operand();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'hffff_ffff;
            3: return 32'd0;
            4: return $urandom_range(0, 40) - 4;
            5: return -$urandom_range(1, 300);
            default: return $urandom;
        endcase
    endfunction

    task automatic send_item(logic [3:0] kind, logic [31:0] a, logic [31:0] b);
        int n;
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            n = $urandom_range(1, 4);
            cmd.valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
        cmd.valid <= 1'b1;
        cmd.kind <= kind;
        cmd.operand_a <= a;
        cmd.operand_b <= b;
        @(posedge clk);
        while (!cmd.ready)
            @(posedge clk);
        sent++;
    endtask

    task automatic drain();
        cmd.valid <= 1'b0;
        @(posedge clk);
        while (board.pending.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        logic [3:0] k;
        @(posedge rst_n);
        @(posedge clk);
        // Directed: extremes, each operation, and the corner cases.
        for (int op = 0; op < 16; op++)
            send_item(4'(op), 32'h8000_0000, 32'h7fff_ffff);
        send_item(OP_DIV, 32'h8000_0000, 32'hffff_ffff);
        send_item(OP_REM, 32'h8000_0000, 32'hffff_ffff);
        send_item(OP_DIV, 32'd77, 32'd0);
        send_item(OP_REM, -32'sd77, 32'd0);
        send_item(OP_DIV, -32'sd7, 32'd2);
        send_item(OP_REM, -32'sd7, 32'd2);
        send_item(OP_SHL, 32'hffff_ffff, 32'd31);
        send_item(OP_SAR, 32'h8000_0000, 32'd31);
        send_item(OP_SHL, 32'd1, 32'd32);
        send_item(OP_SAR, 32'd1, 32'hffff_ffff);
        // Hold off until the pipe is empty once.
        drain();
        for (int i = 0; i < 1750; i++)
        begin
            if (i == 1500)
                quiet = 1'b1;
            k = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(11, 15))
                                            : 4'($urandom_range(0, 10));
            send_item(k, pick_operand(), pick_operand());
        end
        drain();
        repeat (40) @(posedge clk);
        $display("checked %0d results over %0d items; divides %0d, shifts %0d, bad ops %0d",
                 board.checked, sent, op_seen[OP_DIV] + op_seen[OP_REM],
                 op_seen[OP_SHL] + op_seen[OP_SAR],
                 op_seen[11] + op_seen[12] + op_seen[13] + op_seen[14] + op_seen[15]);
        if (board.mismatches == 0 && board.pending.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule
`default_nettype wire

[files.f]
hdl/ialu_pkg.sv
hdl/ialu_if.sv
hdl/integer_alu_eleven_ops.sv
hdl/ialu_checker.sv
dv/integer_alu_eleven_ops_tb.sv
